/* rtl/lai_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lai_pkg
// Shared constants for the Lagrange axis interpolation weights block.
// ----------------------------------------------------------------------------
package lai_pkg;

    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_MAX_ORDER  = 7;

    localparam int COORD_W  = 32;
    localparam int IDX_W    = 20;
    localparam int WEIGHT_W = 32;
    localparam int ORDER_W  = 3;
    localparam int CMD_W    = 2;
    localparam int STAT_W   = 2;

    localparam logic [WEIGHT_W-1:0] ONE_Q24 = 32'h0100_0000;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_SAT   = 2'd3;

endpackage
`default_nettype wire

/* rtl/lai_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lai_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lai_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* rtl/lagrange_axis_interpolation_weights.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lagrange_axis_interpolation_weights
// Sorted source-point store and Lagrange weight generator for one axis.
// ----------------------------------------------------------------------------
// Items are taken one at a time; s_axis_tready is high only between items,
// while a finished result may still wait on the output register. A load
// shifts each stored point with a larger coordinate up by one place
// (insertion shift through the store RAM read port), then hands the result
// to the output register. A query scans the store once, then places the
// stencil, then for each of the m stencil points builds the weight one
// factor at a time and may wait on an output stall: each factor needs a
// RAM read, a 32x16 and a 32x17 partial product and a 64-step restoring
// divider.
// The store RAM holds no valid bits; a clear only resets the point count.
module lagrange_axis_interpolation_weights
    import lai_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int MAX_ORDER  = DEF_MAX_ORDER
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [ORDER_W-1:0]   i_cfg_wdata,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    // coord_value[31:0], source_index[51:32], dest_index[71:52]
    input  wire [71:0]          s_axis_tdata,
    // command[1:0], point_valid[2]
    input  wire [2:0]           s_axis_tuser,
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    // dest_index_out[19:0], source_index_out[39:20], weight[71:40]
    output logic [71:0]         m_axis_tdata,
    output logic                m_axis_tlast,
    // status[1:0]
    output logic [STAT_W-1:0]   m_axis_tuser
);

    localparam int AW  = $clog2(MAX_POINTS);
    localparam int CW  = $clog2(MAX_POINTS + 1);
    localparam int OW  = $clog2(MAX_ORDER + 2);
    localparam int XW  = ((CW > OW) ? CW : OW) + 1;
    localparam int NW  = 2 * COORD_W;
    localparam int DW  = COORD_W + 1;
    localparam int KW  = $clog2(NW);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LD_RD   = 4'd1;
    localparam logic [3:0] S_LD_CMP  = 4'd2;
    localparam logic [3:0] S_Q_SCAN  = 4'd3;
    localparam logic [3:0] S_Q_INIT  = 4'd4;
    localparam logic [3:0] S_Q_WIDEN = 4'd5;
    localparam logic [3:0] S_Q_CUT   = 4'd6;
    localparam logic [3:0] S_W_XI    = 4'd7;
    localparam logic [3:0] S_W_XI2   = 4'd8;
    localparam logic [3:0] S_W_K     = 4'd9;
    localparam logic [3:0] S_W_XK    = 4'd10;
    localparam logic [3:0] S_W_MUL0  = 4'd11;
    localparam logic [3:0] S_W_MUL1  = 4'd12;
    localparam logic [3:0] S_W_DIV   = 4'd13;
    localparam logic [3:0] S_W_SAT   = 4'd14;
    localparam logic [3:0] S_EMIT    = 4'd15;

    logic [3:0]                 r_state, n_state;
    logic [ORDER_W-1:0]         r_order;
    logic [CW-1:0]              r_n, n_n;
    logic signed [COORD_W-1:0]  r_c, n_c;
    logic [IDX_W-1:0]           r_si, n_si;
    logic [IDX_W-1:0]           r_dst, n_dst;
    logic [CW-1:0]              r_pos, n_pos;
    logic [CW-1:0]              r_scan, n_scan;
    logic                       r_pend, n_pend;
    logic [XW-1:0]              r_lb, n_lb, r_ub, n_ub, r_lo, n_lo, r_hi, n_hi;
    logic                       r_down, n_down;
    logic [OW-1:0]              r_o, n_o, r_k, n_k, r_i, n_i, r_m, n_m;
    logic signed [COORD_W-1:0]  r_xi, n_xi;
    logic [WEIGHT_W-1:0]        r_w, n_w;
    logic [WEIGHT_W-1:0]        r_mw, n_mw;
    logic [DW-1:0]              r_mn, n_mn, r_md, n_md;
    logic                       r_neg, n_neg;
    logic [NW-1:0]              r_prod, n_prod, r_num, n_num;
    logic [DW-1:0]              r_rem, n_rem;
    logic [KW-1:0]              r_cnt, n_cnt;
    logic                       r_sat, n_sat;
    logic [IDX_W-1:0]           r_res_src, n_res_src;
    logic [STAT_W-1:0]          r_res_st, n_res_st;
    logic                       r_res_last, n_res_last;
    logic                       r_ov, n_ov;
    logic [71:0]                r_odata, n_odata;
    logic                       r_olast, n_olast;
    logic [STAT_W-1:0]          r_ost, n_ost;

    logic                       mem_we;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    logic [COORD_W-1:0]         mem_wcoord, rd_coord;
    logic [IDX_W-1:0]           mem_wsrc, rd_src;

    logic [XW-1:0]              nx, ox;
    logic signed [DW-1:0]       den, num;
    logic [DW:0]                div_t;
    logic                       div_ge;
    logic [CMD_W-1:0]           in_cmd;

    lai_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_coord_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wcoord),
        .i_raddr (mem_raddr),
        .o_rdata (rd_coord)
    );

    lai_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wsrc),
        .i_raddr (mem_raddr),
        .o_rdata (rd_src)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_ost;
    assign in_cmd        = s_axis_tuser[1:0];

    assign nx     = XW'(r_n);
    assign ox     = XW'(r_o);
    assign den    = $signed({r_xi[COORD_W-1], r_xi}) - $signed({rd_coord[COORD_W-1], rd_coord});
    assign num    = $signed({r_c[COORD_W-1], r_c}) - $signed({rd_coord[COORD_W-1], rd_coord});
    assign div_t  = {r_rem, r_num[NW-1]};
    assign div_ge = (div_t >= {1'b0, r_md});

    always_comb begin
        n_state    = r_state;
        n_n        = r_n;
        n_c        = r_c;
        n_si       = r_si;
        n_dst      = r_dst;
        n_pos      = r_pos;
        n_scan     = r_scan;
        n_pend     = r_pend;
        n_lb       = r_lb;
        n_ub       = r_ub;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_down     = r_down;
        n_o        = r_o;
        n_k        = r_k;
        n_i        = r_i;
        n_m        = r_m;
        n_xi       = r_xi;
        n_w        = r_w;
        n_mw       = r_mw;
        n_mn       = r_mn;
        n_md       = r_md;
        n_neg      = r_neg;
        n_prod     = r_prod;
        n_num      = r_num;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_sat      = r_sat;
        n_res_src  = r_res_src;
        n_res_st   = r_res_st;
        n_res_last = r_res_last;
        n_ov       = r_ov && !m_axis_tready;
        n_odata    = r_odata;
        n_olast    = r_olast;
        n_ost      = r_ost;
        mem_we     = 1'b0;
        mem_waddr  = r_pos[AW-1:0];
        mem_wcoord = r_c;
        mem_wsrc   = r_si;
        mem_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_c   = s_axis_tdata[31:0];
                    n_si  = s_axis_tdata[51:32];
                    n_dst = '0;
                    n_w   = '0;
                    n_res_last = 1'b1;
                    unique case (in_cmd)
                        CMD_CLEAR: begin
                            n_n = '0;
                        end
                        CMD_LOAD: begin
                            n_res_src = s_axis_tdata[51:32];
                            n_res_st  = ST_OK;
                            if (!s_axis_tuser[2]) begin
                                n_state = S_EMIT;
                            end else if (r_n == CW'(MAX_POINTS)) begin
                                n_res_st = ST_FULL;
                                n_state  = S_EMIT;
                            end else begin
                                n_pos   = r_n;
                                n_state = S_LD_RD;
                            end
                        end
                        CMD_QUERY: begin
                            n_dst = s_axis_tdata[71:52];
                            if (r_n == '0) begin
                                n_res_src = '0;
                                n_res_st  = ST_EMPTY;
                                n_state   = S_EMIT;
                            end else begin
                                n_o = (r_order == '0) ? OW'(1) :
                                      ((32'(r_order) > MAX_ORDER) ? OW'(MAX_ORDER) :
                                       OW'(r_order));
                                n_scan  = '0;
                                n_pend  = 1'b0;
                                n_lb    = '0;
                                n_ub    = '0;
                                n_state = S_Q_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LD_RD: begin
                mem_raddr = AW'(r_pos - CW'(1));
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_n     = r_n + CW'(1);
                    n_state = S_EMIT;
                end else begin
                    n_state = S_LD_CMP;
                end
            end
            S_LD_CMP: begin
                mem_we = 1'b1;
                if ($signed(rd_coord) > r_c) begin
                    mem_wcoord = rd_coord;
                    mem_wsrc   = rd_src;
                    n_pos      = r_pos - CW'(1);
                    n_state    = S_LD_RD;
                end else begin
                    n_n     = r_n + CW'(1);
                    n_state = S_EMIT;
                end
            end
            S_Q_SCAN: begin
                mem_raddr = r_scan[AW-1:0];
                if (r_scan < r_n) begin
                    n_scan = r_scan + CW'(1);
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    n_lb = r_lb + XW'($signed(rd_coord) < r_c);
                    n_ub = r_ub + XW'($signed(rd_coord) <= r_c);
                end
                if (r_scan == r_n && !r_pend) begin
                    n_state = S_Q_INIT;
                end
            end
            S_Q_INIT: begin
                if (r_ub == nx) begin
                    n_lo    = (nx > ox + XW'(1)) ? nx - ox - XW'(1) : '0;
                    n_hi    = nx;
                    n_state = S_Q_CUT;
                end else begin
                    n_lo    = (r_lb != '0) ? r_lb - XW'(1) : r_lb;
                    n_hi    = (r_ub < nx) ? r_ub + XW'(1) : r_ub;
                    n_down  = 1'b1;
                    n_k     = '0;
                    n_state = S_Q_WIDEN;
                end
            end
            S_Q_WIDEN: begin
                if (XW'(r_k) + XW'(1) < ox) begin
                    if (r_lo != '0 && r_down) begin
                        n_lo   = r_lo - XW'(1);
                        n_down = 1'b0;
                    end else if (r_hi < nx) begin
                        n_hi   = r_hi + XW'(1);
                        n_down = 1'b1;
                    end
                    n_k = r_k + OW'(1);
                end else begin
                    n_state = S_Q_CUT;
                end
            end
            S_Q_CUT: begin
                if (r_hi - r_lo > ox + XW'(1)) begin
                    n_hi = r_lo + ox + XW'(1);
                    n_m  = r_o + OW'(1);
                end else begin
                    n_m  = OW'(r_hi - r_lo);
                end
                n_i     = '0;
                n_state = S_W_XI;
            end
            S_W_XI: begin
                mem_raddr = AW'(r_lo + XW'(r_i));
                n_state   = S_W_XI2;
            end
            S_W_XI2: begin
                n_xi      = rd_coord;
                n_res_src = rd_src;
                n_w       = ONE_Q24;
                n_k       = '0;
                n_sat     = 1'b0;
                n_state   = S_W_K;
            end
            S_W_K: begin
                mem_raddr = AW'(r_lo + XW'(r_k));
                if (r_k == r_m) begin
                    n_res_st   = r_sat ? ST_SAT : ST_OK;
                    n_res_last = (r_i + OW'(1) == r_m);
                    n_state    = S_EMIT;
                end else if (r_k == r_i) begin
                    n_k = r_k + OW'(1);
                end else begin
                    n_state = S_W_XK;
                end
            end
            S_W_XK: begin
                if (den == '0) begin
                    n_w        = '0;
                    n_res_st   = ST_SAT;
                    n_res_last = (r_i + OW'(1) == r_m);
                    n_state    = S_EMIT;
                end else begin
                    n_mw    = r_w[WEIGHT_W-1] ? WEIGHT_W'(0) - r_w : r_w;
                    n_mn    = num[DW-1] ? DW'(0) - DW'(num) : DW'(num);
                    n_md    = den[DW-1] ? DW'(0) - DW'(den) : DW'(den);
                    n_neg   = r_w[WEIGHT_W-1] ^ num[DW-1] ^ den[DW-1];
                    n_state = S_W_MUL0;
                end
            end
            S_W_MUL0: begin
                n_prod  = NW'(r_mw * r_mn[15:0]) + NW'(r_md >> 1);
                n_state = S_W_MUL1;
            end
            S_W_MUL1: begin
                n_num   = r_prod + (NW'(r_mw * r_mn[DW-1:16]) << 16);
                n_rem   = '0;
                n_cnt   = '0;
                n_state = S_W_DIV;
            end
            S_W_DIV: begin
                n_rem = div_ge ? DW'(div_t - {1'b0, r_md}) : div_t[DW-1:0];
                n_num = {r_num[NW-2:0], div_ge};
                n_cnt = r_cnt + KW'(1);
                if (r_cnt == KW'(NW - 1)) begin
                    n_state = S_W_SAT;
                end
            end
            S_W_SAT: begin
                if (r_neg) begin
                    if (r_num > NW'(64'h8000_0000)) begin
                        n_sat = 1'b1;
                        n_w   = 32'h8000_0000;
                    end else begin
                        n_w   = WEIGHT_W'(0) - r_num[WEIGHT_W-1:0];
                    end
                end else begin
                    if (r_num > NW'(64'h7FFF_FFFF)) begin
                        n_sat = 1'b1;
                        n_w   = 32'h7FFF_FFFF;
                    end else begin
                        n_w   = r_num[WEIGHT_W-1:0];
                    end
                end
                n_k     = r_k + OW'(1);
                n_state = S_W_K;
            end
            S_EMIT: begin
                if (!r_ov || m_axis_tready) begin
                    n_ov    = 1'b1;
                    n_odata = {r_w, r_res_src, r_dst};
                    n_olast = r_res_last;
                    n_ost   = r_res_st;
                    if (r_res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + OW'(1);
                        n_state = S_W_XI;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_order <= ORDER_W'(1);
            r_n     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_ov    <= n_ov;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_c        <= n_c;
        r_si       <= n_si;
        r_dst      <= n_dst;
        r_pos      <= n_pos;
        r_scan     <= n_scan;
        r_pend     <= n_pend;
        r_lb       <= n_lb;
        r_ub       <= n_ub;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_down     <= n_down;
        r_o        <= n_o;
        r_k        <= n_k;
        r_i        <= n_i;
        r_m        <= n_m;
        r_xi       <= n_xi;
        r_w        <= n_w;
        r_mw       <= n_mw;
        r_mn       <= n_mn;
        r_md       <= n_md;
        r_neg      <= n_neg;
        r_prod     <= n_prod;
        r_num      <= n_num;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_sat      <= n_sat;
        r_res_src  <= n_res_src;
        r_res_st   <= n_res_st;
        r_res_last <= n_res_last;
        r_odata    <= n_odata;
        r_olast    <= n_olast;
        r_ost      <= n_ost;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(MAX_POINTS))
        else $error("point count above store depth");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser[1:0] == CMD_CLEAR) |=> (r_n == '0))
        else $error("clear did not empty the store");

    a_emit_in_stencil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_res_last) |-> (r_i + OW'(1) < r_m))
        else $error("stencil index past stencil size");
`endif

endmodule
`default_nettype wire
